>>> hdl/assert_macros.svh
// Assertion macros used by the RTL file polyphonic_tone_table.sv.
// They expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Implication check failed.");

`define PPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`else

`define PPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/ppt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

    localparam logic [1:0] OP_ACTIVATE   = 2'd0;
    localparam logic [1:0] OP_DEACTIVATE = 2'd1;
    localparam logic [1:0] OP_EXPIRE     = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  note;
        logic [31:0] start_time;
        logic [31:0] sustain_time;
        logic [31:0] now_time;
    } in_word_t;

    typedef struct packed {
        logic       status;
        logic [4:0] active_count;
    } out_word_t;

    typedef struct packed {
        logic [6:0]  note;
        logic [31:0] start_time;
        logic [31:0] sustain_time;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TEST,
        ST_READ_LAST,
        ST_MOVE,
        ST_APPEND,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> hdl/ppt_entry_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ppt_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire ppt_pkg::entry_t   wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output ppt_pkg::entry_t        rd_data
);
    import ppt_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/ppt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ppt_ctrl #(
    parameter int POLYPHONY = 16,
    parameter int CNT_W     = 5,
    parameter int IDX_W     = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ppt_pkg::in_word_t in_data,
    input  wire logic             out_free,
    output logic                  res_done,
    output ppt_pkg::out_word_t    res_data,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output ppt_pkg::entry_t       ram_wdata,
    output logic [IDX_W-1:0]      ram_raddr,
    input  wire ppt_pkg::entry_t  ram_rdata
);
    import ppt_pkg::*;

    localparam logic [CNT_W-1:0] POLY_CNT = CNT_W'(POLYPHONY);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             status_reg, status_next;
    in_word_t         item_reg, item_next;

    logic [CNT_W-1:0] last_cnt;
    logic [32:0]      end_sum;
    logic             expired;
    logic             hit;
    logic             scan_done;

    assign last_cnt  = count_reg - CNT_W'(1);
    assign end_sum   = {1'b0, ram_rdata.start_time} + {1'b0, ram_rdata.sustain_time};
    assign expired   = end_sum <= {1'b0, item_reg.now_time};
    assign hit       = (item_reg.operation == OP_EXPIRE) ? expired
                                                         : (ram_rdata.note == item_reg.note);
    assign scan_done = idx_reg >= count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= STATUS_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_data.operation inside {OP_ACTIVATE, OP_DEACTIVATE, OP_EXPIRE}) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_READ: begin
                if (scan_done) begin
                    if (item_reg.operation == OP_ACTIVATE && count_reg < POLY_CNT) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (hit) begin
                    state_next = (item_reg.operation == OP_ACTIVATE) ? ST_FINISH : ST_READ_LAST;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ_LAST: state_next = ST_MOVE;
            ST_MOVE:      state_next = ST_READ;
            ST_APPEND:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        res_done    = 1'b0;
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        item_next   = item_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[IDX_W-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next   = in_data;
                    idx_next    = '0;
                    status_next = STATUS_OK;
                end
            end
            ST_READ: begin
                if (scan_done && item_reg.operation == OP_ACTIVATE
                        && count_reg >= POLY_CNT) begin
                    status_next = STATUS_FULL;
                end
            end
            ST_TEST: begin
                if (!hit) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_READ_LAST: begin
                ram_raddr = last_cnt[IDX_W-1:0];
            end
            ST_MOVE: begin
                ram_we     = 1'b1;
                count_next = last_cnt;
            end
            ST_APPEND: begin
                ram_we                 = 1'b1;
                ram_waddr              = count_reg[IDX_W-1:0];
                ram_wdata.note         = item_reg.note;
                ram_wdata.start_time   = item_reg.start_time;
                ram_wdata.sustain_time = item_reg.sustain_time;
                count_next             = count_reg + CNT_W'(1);
            end
            ST_FINISH: begin
                res_done = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res_data.status       = status_reg;
    assign res_data.active_count = 5'(count_reg);

endmodule

`default_nettype wire

>>> hdl/polyphonic_tone_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                        Word
// input     s_valid, s_ready, s_data     ppt_pkg::in_word_t
// result    m_valid, m_ready, m_data     ppt_pkg::out_word_t
//
// One word is handled at a time; s_ready is high only while the sequencer is idle.
// A word reads and tests the entries in turn. Activate stops at a note already present
// and else appends it if the table has room; deactivate and expire move the last entry
// into the place of each removed one, and an unused code goes straight to the finish.
// Reset is synchronous and empties the table. The last cycle of a word waits while the
// output register holds an unread result, which sits there while the next word is taken.

`include "assert_macros.svh"

module polyphonic_tone_table #(
    parameter int POLYPHONY = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ppt_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ppt_pkg::out_word_t     m_data
);
    import ppt_pkg::*;

    localparam int CNT_W   = $clog2(POLYPHONY + 1);
    localparam int IDX_W   = (POLYPHONY > 1) ? $clog2(POLYPHONY) : 1;
    localparam int ACT_MAX = (POLYPHONY > 31) ? 31 : POLYPHONY;

    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;
    logic             out_free;
    logic             res_done;
    out_word_t        res_data;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    assign out_free = !m_valid_reg || m_ready;

    ppt_ctrl #(
        .POLYPHONY (POLYPHONY),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_free  (out_free),
        .res_done  (res_done),
        .res_data  (res_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ppt_entry_ram #(
        .DEPTH  (POLYPHONY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_done) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PPT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PPT_ASSERT_NXT(a_result_registered, aclk, aresetn, res_done, m_valid && m_data == $past(res_data))
    `PPT_ASSERT_IMP(a_count_bound, aclk, aresetn, m_valid, m_data.active_count <= 5'(ACT_MAX))
    `PPT_ASSERT_IMP(a_full_count, aclk, aresetn, m_valid && m_data.status == STATUS_FULL, m_data.active_count == 5'(POLYPHONY))

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ppt_pkg::*;

    localparam int POLYPHONY = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1225;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  note;
        logic [31:0] start_tick;
        logic [31:0] sustain_ticks;
        logic [31:0] now_tick;
        logic        given;
        logic        want_status;
        logic [4:0]  want_count;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    logic [6:0]  slot_note [POLYPHONY];
    logic [31:0] tone_start [POLYPHONY];
    logic [31:0] tone_sustain [POLYPHONY];
    int unsigned tone_count = 0;

    out_word_t   expected_results [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 7;
    int unsigned recv_idle_pct = 69;
    bit          hold_request;
    bit          hold_off;
    logic [31:0] tick_now = 32'd0;

    // The table is filled to capacity with note 127 and notes 1 to 15 so that an absent note
    // overflows while a present one is still accepted as a duplicate.
    dir_row_t directed_rows [27] = '{
        '{OP_EXPIRE,     7'd0,   32'd0,          32'd0,          32'd0,          1'b1, STATUS_OK,   5'd0},
        '{OP_DEACTIVATE, 7'd5,   32'd0,          32'd0,          32'd0,          1'b1, STATUS_OK,   5'd0},
        '{OP_UNUSED,     7'd127, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, STATUS_OK,   5'd0},
        '{OP_ACTIVATE,   7'd0,   32'd0,          32'd0,          32'd0,          1'b1, STATUS_OK,   5'd1},
        '{OP_ACTIVATE,   7'd127, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          1'b1, STATUS_OK,   5'd2},
        '{OP_ACTIVATE,   7'd0,   32'd5,          32'd5,          32'd0,          1'b1, STATUS_OK,   5'd2},
        '{OP_EXPIRE,     7'd0,   32'd0,          32'd0,          32'd0,          1'b1, STATUS_OK,   5'd1},
        '{OP_EXPIRE,     7'd0,   32'd0,          32'd0,          32'hFFFF_FFFF,  1'b1, STATUS_OK,   5'd1},
        '{OP_ACTIVATE,   7'd1,   32'd100,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd2},
        '{OP_ACTIVATE,   7'd2,   32'd200,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd3},
        '{OP_ACTIVATE,   7'd3,   32'd300,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd4},
        '{OP_ACTIVATE,   7'd4,   32'd400,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd5},
        '{OP_ACTIVATE,   7'd5,   32'd500,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd6},
        '{OP_ACTIVATE,   7'd6,   32'd600,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd7},
        '{OP_ACTIVATE,   7'd7,   32'd700,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd8},
        '{OP_ACTIVATE,   7'd8,   32'd800,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd9},
        '{OP_ACTIVATE,   7'd9,   32'd900,        32'd10,         32'd0,          1'b1, STATUS_OK,   5'd10},
        '{OP_ACTIVATE,   7'd10,  32'd1000,       32'd10,         32'd0,          1'b1, STATUS_OK,   5'd11},
        '{OP_ACTIVATE,   7'd11,  32'd1100,       32'd10,         32'd0,          1'b1, STATUS_OK,   5'd12},
        '{OP_ACTIVATE,   7'd12,  32'd1200,       32'd10,         32'd0,          1'b1, STATUS_OK,   5'd13},
        '{OP_ACTIVATE,   7'd13,  32'd1300,       32'd10,         32'd0,          1'b1, STATUS_OK,   5'd14},
        '{OP_ACTIVATE,   7'd14,  32'd1400,       32'd10,         32'd0,          1'b1, STATUS_OK,   5'd15},
        '{OP_ACTIVATE,   7'd15,  32'd1500,       32'd10,         32'd0,          1'b1, STATUS_OK,   5'd16},
        '{OP_ACTIVATE,   7'd64,  32'd0,          32'd0,          32'd0,          1'b1, STATUS_FULL, 5'd16},
        '{OP_ACTIVATE,   7'd127, 32'd0,          32'd0,          32'd0,          1'b1, STATUS_OK,   5'd16},
        '{OP_EXPIRE,     7'd0,   32'd0,          32'd0,          32'd510,        1'b0, STATUS_OK,   5'd0},
        '{OP_DEACTIVATE, 7'd127, 32'd0,          32'd0,          32'd0,          1'b0, STATUS_OK,   5'd0}
    };

    polyphonic_tone_table #(
        .POLYPHONY(POLYPHONY)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void remove_tone(input int unsigned pos);
        int unsigned last;
        last = tone_count - 1;
        slot_note[pos] = slot_note[last];
        tone_start[pos] = tone_start[last];
        tone_sustain[pos] = tone_sustain[last];
        tone_count = last;
    endfunction

    function automatic out_word_t apply_tone_event(input in_word_t w);
        out_word_t   res;
        int unsigned i;
        bit          found;
        logic [32:0] end_tick;
        res.status = STATUS_OK;
        case (w.operation)
            OP_ACTIVATE: begin
                found = 1'b0;
                for (i = 0; i < tone_count; i++) begin
                    if (slot_note[i] == w.note) begin
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    if (tone_count >= POLYPHONY) begin
                        res.status = STATUS_FULL;
                    end else begin
                        slot_note[tone_count] = w.note;
                        tone_start[tone_count] = w.start_time;
                        tone_sustain[tone_count] = w.sustain_time;
                        tone_count++;
                    end
                end
            end
            OP_DEACTIVATE: begin
                i = 0;
                while (i < tone_count) begin
                    if (slot_note[i] == w.note) begin
                        remove_tone(i);
                    end else begin
                        i++;
                    end
                end
            end
            OP_EXPIRE: begin
                i = 0;
                while (i < tone_count) begin
                    end_tick = {1'b0, tone_start[i]} + {1'b0, tone_sustain[i]};
                    if (end_tick <= {1'b0, w.now_time}) begin
                        remove_tone(i);
                    end else begin
                        i++;
                    end
                end
            end
            default: begin
            end
        endcase
        res.active_count = tone_count[4:0];
        return res;
    endfunction

    // Most words follow a slowly advancing tick on a small pool of notes, so
    // that notes collide, the table fills up and entries expire in bunches.
    function automatic in_word_t random_tone_word(input int unsigned act_pct);
        in_word_t    w;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        tick_now = tick_now + $urandom_range(40, 0);
        w.note = ($urandom_range(9, 0) < 8) ? 7'($urandom_range(23, 0))
                                            : 7'($urandom_range(127, 0));
        w.start_time = $urandom;
        w.sustain_time = $urandom;
        w.now_time = $urandom;
        if (pick < act_pct) begin
            w.operation = OP_ACTIVATE;
            if ($urandom_range(9, 0) != 0) begin
                w.start_time = tick_now - $urandom_range(50, 0);
                w.sustain_time = $urandom_range(2000, 0);
            end
        end else if (pick < act_pct + 25) begin
            w.operation = OP_DEACTIVATE;
        end else if (pick < 97) begin
            w.operation = OP_EXPIRE;
            if ($urandom_range(9, 0) != 0) begin
                w.now_time = tick_now;
            end
        end else begin
            w.operation = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
            @(negedge aclk);
        end
    end

    initial begin
        wait (hold_request);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word: status %0d, active_count %0d",
                       m_data.status, m_data.active_count);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.active_count !== want.active_count) begin
                    $error("active_count: expected %0d, actual %0d",
                           want.active_count, m_data.active_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        in_word_t    w;
        out_word_t   res;
        int unsigned k;
        int unsigned phase;
        int unsigned act_pct;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < $size(directed_rows); k++) begin
            w.operation = directed_rows[k].op;
            w.note = directed_rows[k].note;
            w.start_time = directed_rows[k].start_tick;
            w.sustain_time = directed_rows[k].sustain_ticks;
            w.now_time = directed_rows[k].now_tick;
            send_word(w);
            res = apply_tone_event(w);
            if (directed_rows[k].given) begin
                res.status = directed_rows[k].want_status;
                res.active_count = directed_rows[k].want_count;
            end
            expected_results.push_back(res);
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 69;
                    act_pct = 50;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_idle_pct = 7;
                    act_pct = 40;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    act_pct = 45;
                    hold_request = 1'b1;
                end
            endcase
            repeat (RANDOM_WORDS / 3) begin
                w = random_tone_word(act_pct);
                send_word(w);
                expected_results.push_back(apply_tone_event(w));
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
